// ===== rtl/core/dre_pkg.sv =====
// shared constants, divider request/response structs and sequencer states
// for the departure rate estimator; no dependencies
package dre_pkg;

    // fixed-point and queue width choices
    localparam int RATE_FRAC_BITS    = 16;
    localparam int QUEUE_BYTES_WIDTH = 24;

    // field widths
    localparam int PKT_W    = 16;
    localparam int QIN_W    = 24;
    localparam int TIME_W   = 48;
    localparam int THR_W    = 20;
    localparam int BYTES_W  = 32;
    localparam int RATE_W   = 40;
    localparam int DELAY_W  = 32;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2000);

    // effective queue byte width after both masks
    localparam int QB_W = (QUEUE_BYTES_WIDTH < QIN_W) ? QUEUE_BYTES_WIDTH : QIN_W;

    // divider width covers both dividends and both divisors
    localparam int SAMPLE_DVD_W = BYTES_W + RATE_FRAC_BITS;
    localparam int DIV_W        = (SAMPLE_DVD_W > TIME_W) ? SAMPLE_DVD_W : TIME_W;
    localparam int CNT_W        = $clog2(DIV_W);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SAMPLE,
        ST_DELAY_GO,
        ST_DELAY,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/core/dre_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on dre_pkg
module dre_div
    import dre_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;

    // one shift-subtract step
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/departure_rate_estimator.sv =====
// departure rate estimator top level: window tracking, rate averaging,
// queue delay; depends on dre_pkg and dre_div
//
// channel   direction  handshake             payload
// s_        in         s_valid / s_ready     packet_bytes, queue_bytes, now_ticks
// m_        out        m_valid / m_ready     rate_fixed, queue_delay_ticks, measuring,
//                                            rate_updated
// cfg_      in         cfg_valid / cfg_ready threshold_bytes (cfg_data)
//
// an item passes through ST_EVAL, ST_SAMPLE when a rate sample is taken, ST_DELAY_GO,
// ST_DELAY unless the rate is zero, and ST_FINISH, in that order;
// both divisions run on the one bit-per-cycle divider. s_ready is high only while
// the sequencer is idle. the result register frees the input side: a new item is
// taken while the previous result still waits on m_ready. reset is synchronous,
// active low, and clears window state, rate and the threshold to its default.
// cfg_ready is always high.
module departure_rate_estimator
    import dre_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PKT_W-1:0]   s_packet_bytes,
    input  logic [QIN_W-1:0]   s_queue_bytes,
    input  logic [TIME_W-1:0]  s_now_ticks,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [RATE_W-1:0]  m_rate_fixed,
    output logic [DELAY_W-1:0] m_queue_delay_ticks,
    output logic               m_measuring,
    output logic               m_rate_updated,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [THR_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [THR_W-1:0]   thr_reg;
    logic               win_open_reg, win_open_next;
    logic [TIME_W-1:0]  win_start_reg, win_start_next;
    logic [BYTES_W-1:0] win_bytes_reg, win_bytes_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic               upd_reg, upd_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;

    // latched input item
    logic [PKT_W-1:0]   pkt_reg;
    logic [QB_W-1:0]    qb_reg;
    logic [TIME_W-1:0]  now_reg;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [RATE_W-1:0]  o_rate_reg;
    logic [DELAY_W-1:0] o_delay_reg;
    logic               o_meas_reg;
    logic               o_upd_reg;
    logic               load_out;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // window evaluation terms
    logic               opening;
    logic               open_now;
    logic [TIME_W-1:0]  start_now;
    logic [BYTES_W-1:0] base_bytes;
    logic [BYTES_W:0]   sum_bytes;
    logic [BYTES_W-1:0] bytes_now;
    logic               complete;
    logic               q_above;
    logic [TIME_W:0]    elapsed;
    logic               later;

    // sample and delay terms
    logic [RATE_W-1:0]  sample;
    logic [RATE_W:0]    rate_sum;
    logic [DELAY_W-1:0] delay_sat;

    logic s_acc;

    dre_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // window update for the latched item
    assign opening    = !win_open_reg && (BYTES_W'(qb_reg) >= BYTES_W'(thr_reg));
    assign open_now   = win_open_reg || opening;
    assign start_now  = opening ? now_reg : win_start_reg;
    assign base_bytes = opening ? '0 : win_bytes_reg;
    assign sum_bytes  = {1'b0, base_bytes} + (BYTES_W + 1)'(pkt_reg);
    assign bytes_now  = sum_bytes[BYTES_W] ? '1 : sum_bytes[BYTES_W-1:0];
    assign complete   = open_now && (bytes_now >= BYTES_W'(thr_reg));
    assign q_above    = BYTES_W'(qb_reg) > BYTES_W'(thr_reg);
    assign elapsed    = {1'b0, now_reg} - {1'b0, start_now};
    assign later      = !elapsed[TIME_W] && (elapsed[TIME_W-1:0] != '0);

    // saturated sample and half-and-half average
    assign sample   = (|div_rsp.quotient[DIV_W-1:RATE_W]) ? '1
                                                          : div_rsp.quotient[RATE_W-1:0];
    assign rate_sum = {1'b0, rate_reg} + {1'b0, sample};

    // saturated queue delay
    assign delay_sat = (|div_rsp.quotient[DIV_W-1:DELAY_W]) ? '1
                                                            : div_rsp.quotient[DELAY_W-1:0];

    // sequencer
    always_comb begin
        state_next       = state_reg;
        win_open_next    = win_open_reg;
        win_start_next   = win_start_reg;
        win_bytes_next   = win_bytes_reg;
        rate_next        = rate_reg;
        upd_next         = upd_reg;
        delay_next       = delay_reg;
        load_out         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(bytes_now) << RATE_FRAC_BITS;
        div_req.divisor  = DIV_W'(elapsed[TIME_W-1:0]);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                upd_next = 1'b0;
                if (complete) begin
                    win_bytes_next = '0;
                    win_open_next  = q_above;
                    win_start_next = q_above ? now_reg : start_now;
                end else if (open_now) begin
                    win_open_next  = 1'b1;
                    win_start_next = start_now;
                    win_bytes_next = bytes_now;
                end
                if (complete && later) begin
                    div_req.start = 1'b1;
                    state_next    = ST_SAMPLE;
                end else begin
                    state_next = ST_DELAY_GO;
                end
            end
            ST_SAMPLE: begin
                if (div_rsp.done) begin
                    rate_next  = (rate_reg == '0) ? sample : rate_sum[RATE_W:1];
                    upd_next   = 1'b1;
                    state_next = ST_DELAY_GO;
                end
            end
            ST_DELAY_GO: begin
                div_req.dividend = DIV_W'(qb_reg) << RATE_FRAC_BITS;
                div_req.divisor  = DIV_W'(rate_reg);
                if (rate_reg == '0) begin
                    delay_next = '0;
                    state_next = ST_FINISH;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DELAY;
                end
            end
            ST_DELAY: begin
                if (div_rsp.done) begin
                    delay_next = delay_sat;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = load_out || (m_valid_reg && !m_ready);

    // control and estimator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            win_open_reg  <= 1'b0;
            win_start_reg <= '0;
            win_bytes_reg <= '0;
            rate_reg      <= '0;
            upd_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            win_open_reg  <= win_open_next;
            win_start_reg <= win_start_next;
            win_bytes_reg <= win_bytes_next;
            rate_reg      <= rate_next;
            upd_reg       <= upd_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
        end
    end

    // item capture, delay and result payload
    always_ff @(posedge aclk) begin
        delay_reg <= delay_next;
        if (s_acc) begin
            pkt_reg <= s_packet_bytes;
            qb_reg  <= s_queue_bytes[QB_W-1:0];
            now_reg <= s_now_ticks;
        end
        if (load_out) begin
            o_rate_reg  <= rate_reg;
            o_delay_reg <= delay_reg;
            o_meas_reg  <= win_open_reg;
            o_upd_reg   <= upd_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_rate_fixed        = o_rate_reg;
    assign m_queue_delay_ticks = o_delay_reg;
    assign m_measuring         = o_meas_reg;
    assign m_rate_updated      = o_upd_reg;

endmodule
